// ----- sv/midi_mbp_pkg.sv -----
// Shared types, byte codes and parse state codes for the MIDI message boundary parser.
package midi_mbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int STATE_W = 3;
	localparam int CFG_IDX_W = 2;

	// parse state codes; the spare code behaves as unknown
	localparam logic [STATE_W-1:0] ST_UNKNOWN   = 3'd0;
	localparam logic [STATE_W-1:0] ST_ONE_FIRST = 3'd1;
	localparam logic [STATE_W-1:0] ST_ONE_MORE  = 3'd2;
	localparam logic [STATE_W-1:0] ST_TWO_FIRST = 3'd3;
	localparam logic [STATE_W-1:0] ST_TWO_SEC   = 3'd4;
	localparam logic [STATE_W-1:0] ST_TWO_MORE  = 3'd5;
	localparam logic [STATE_W-1:0] ST_SYSEX     = 3'd6;

	// byte codes
	localparam logic [BYTE_W-1:0] STATUS_FIRST    = 8'h80;
	localparam logic [BYTE_W-1:0] CH_ONE_LO       = 8'hC0;
	localparam logic [BYTE_W-1:0] CH_ONE_HI       = 8'hDF;
	localparam logic [BYTE_W-1:0] SYS_FIRST       = 8'hF0;
	localparam logic [BYTE_W-1:0] SYSEX_START     = 8'hF0;
	localparam logic [BYTE_W-1:0] SYS_MTC         = 8'hF1;
	localparam logic [BYTE_W-1:0] SYS_SONG_POS    = 8'hF2;
	localparam logic [BYTE_W-1:0] SYS_SONG_SEL    = 8'hF3;
	localparam logic [BYTE_W-1:0] SYSEX_END       = 8'hF7;
	localparam logic [BYTE_W-1:0] RT_FIRST        = 8'hF8;
	localparam logic [BYTE_W-1:0] RT_CLOCK        = 8'hF8;
	localparam logic [BYTE_W-1:0] RT_ACTIVE_SENSE = 8'hFE;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_CLOCK          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_ACTIVE_SENSING = 2'd1;

	typedef struct packed {
		logic pass_clock;
		logic pass_active_sensing;
	} cfg_t;

	typedef struct packed {
		logic               keep;
		logic               starts;
		logic               running;
		logic [STATE_W-1:0] next_state;
	} step_res_t;

endpackage

// ----- sv/midi_message_boundary_parser.sv -----
// Top level: MIDI byte stream parser that marks message starts and running-status repeats.
// A result appears in the cycle after its input transfer, from the output register.
// Throughput: one byte per cycle; in_ready follows out_ready while a result is held.
// Filtered real-time bytes are taken and give no result.
// Reset (arst_n low, asynchronous): parse state unknown, both pass registers 0,
// output register empty.
module midi_message_boundary_parser
	import midi_mbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    midi_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 starts_message,
	output logic                 running_repeat
);

	cfg_t               cfg_q;
	logic [STATE_W-1:0] parse_state_q;
	step_res_t          step_res;

	logic              out_valid_q;
	logic [BYTE_W-1:0] data_byte_q;
	logic              starts_q;
	logic              running_q;

	logic in_xfer;

	// Take a new byte whenever the output register is empty or drains this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	midi_mbp_step u_step (
		.midi_byte (midi_byte),
		.state     (parse_state_q),
		.cfg       (cfg_q),
		.res       (step_res)
	);

	// Configuration writes; indexes beyond the list fall through and are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PASS_CLOCK:          cfg_q.pass_clock <= cfg_data;
				CFG_PASS_ACTIVE_SENSING: cfg_q.pass_active_sensing <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the parse state only on a kept byte; a dropped byte leaves it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state_q <= ST_UNKNOWN;
		end else if (in_xfer && step_res.keep) begin
			parse_state_q <= step_res.next_state;
		end
	end

	// Output register: load on a kept byte, clear once the result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= step_res.keep;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; hold it while the result waits.
	always_ff @(posedge clk) begin
		if (in_xfer && step_res.keep) begin
			data_byte_q <= midi_byte;
			starts_q    <= step_res.starts;
			running_q   <= step_res.running;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = data_byte_q;
	assign starts_message = starts_q;
	assign running_repeat = running_q;

endmodule

// ----- sv/midi_mbp_step.sv -----
// Combinational parse step: filter, message-start flags and next parse state for one byte.
module midi_mbp_step
	import midi_mbp_pkg::*;
(
	input  logic [BYTE_W-1:0]  midi_byte,
	input  logic [STATE_W-1:0] state,
	input  cfg_t               cfg,
	output step_res_t          res
);

	always_comb begin
		res.keep = !((midi_byte == RT_CLOCK && !cfg.pass_clock) ||
			(midi_byte == RT_ACTIVE_SENSE && !cfg.pass_active_sensing));
		res.starts     = 1'b0;
		res.running    = 1'b0;
		res.next_state = state;

		if (midi_byte >= RT_FIRST) begin
			res.starts = 1'b1;
		end else if (midi_byte >= SYS_FIRST) begin
			res.starts = 1'b1;
			unique case (midi_byte) inside
				SYSEX_START:           res.next_state = ST_SYSEX;
				SYS_MTC, SYS_SONG_SEL: res.next_state = ST_ONE_FIRST;
				SYS_SONG_POS:          res.next_state = ST_TWO_FIRST;
				SYSEX_END: begin
					res.starts     = (state != ST_SYSEX);
					res.next_state = ST_UNKNOWN;
				end
				default:               res.next_state = ST_UNKNOWN;
			endcase
		end else if (midi_byte >= STATUS_FIRST) begin
			res.starts     = 1'b1;
			res.next_state = (midi_byte >= CH_ONE_LO && midi_byte <= CH_ONE_HI) ?
				ST_ONE_FIRST : ST_TWO_FIRST;
		end else begin
			unique case (state)
				ST_ONE_FIRST: res.next_state = ST_ONE_MORE;
				ST_ONE_MORE:  res.running = 1'b1;
				ST_TWO_FIRST: res.next_state = ST_TWO_SEC;
				ST_TWO_SEC:   res.next_state = ST_TWO_MORE;
				ST_TWO_MORE: begin
					res.running    = 1'b1;
					res.next_state = ST_TWO_SEC;
				end
				ST_SYSEX:     res.next_state = ST_SYSEX;
				default: begin
					// stray data byte
					res.next_state = ST_UNKNOWN;
					res.starts     = 1'b1;
				end
			endcase
		end
	end

endmodule

// ----- sv/midi_mbp_checker.sv -----
// Port-level checker for the MIDI message boundary parser, bound to the top level.
module midi_mbp_checker
	import midi_mbp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] data_byte,
	input logic              starts_message,
	input logic              running_repeat
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
			$stable(starts_message) && $stable(running_repeat))
		else $error("stalled result changed");

	// with the output register free, the parser must take input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while output empty");

	// a repeat marks only a data byte, never a message start
	a_repeat_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running_repeat |-> !starts_message && !data_byte[BYTE_W-1])
		else $error("running repeat on status byte or start");

	// every status byte but SysEx end starts a message
	a_status_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_byte[BYTE_W-1] && data_byte != SYSEX_END |-> starts_message)
		else $error("status byte without message start");

endmodule

bind midi_message_boundary_parser midi_mbp_checker u_midi_mbp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.data_byte      (data_byte),
	.starts_message (starts_message),
	.running_repeat (running_repeat)
);
